[rtl/core/wcct_pkg.sv]
// ----------------------------------------------------------------------------
// wcct_pkg
// Shared widths, limits and class codes of the centroid cluster tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package wcct_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int WEIGHT_W       = 16;
   localparam int RADIUS_W       = 16;
   localparam int CLASS_W        = 2;
   localparam int CNT_W          = 16;
   localparam int SUM_W          = 48;
   localparam int TW_W           = 32;
   localparam int NUM_CLASSES    = 3;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [CNT_W-1:0]        CNT_MAX = {CNT_W{1'b1}};
   localparam logic [TW_W-1:0]         TW_MAX  = {TW_W{1'b1}};

   localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_1    = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_2    = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_3    = 2'd3;

   typedef logic [CNT_W-1:0] vote_cnt_type [NUM_CLASSES];

endpackage

`default_nettype wire

[rtl/core/wcct_req_if.sv]
// ----------------------------------------------------------------------------
// wcct_req_if
// Point channel: position, weight and class vote with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface wcct_req_if #(
   parameter int COORD_BITS = wcct_pkg::COORD_BITS_DEF
);
   import wcct_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic [WEIGHT_W-1:0]         weight;
   logic [CLASS_W-1:0]          class_vote;

   modport source (output valid, output pos_x, output pos_y, output weight,
                   output class_vote, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input weight,
                   input class_vote, output ready);
endinterface

`default_nettype wire

[rtl/core/wcct_rsp_if.sv]
// ----------------------------------------------------------------------------
// wcct_rsp_if
// Result channel: inclusion flag, class, centroid and update count.
// ----------------------------------------------------------------------------
`default_nettype none

interface wcct_rsp_if #(
   parameter int COORD_BITS = wcct_pkg::COORD_BITS_DEF
);
   import wcct_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         included;
   logic [CLASS_W-1:0]           object_class;
   logic signed [COORD_BITS-1:0] centroid_x;
   logic signed [COORD_BITS-1:0] centroid_y;
   logic [CNT_W-1:0]             update_count;

   modport source (output valid, output included, output object_class,
                   output centroid_x, output centroid_y, output update_count,
                   input ready);
   modport sink   (input valid, input included, input object_class,
                   input centroid_x, input centroid_y, input update_count,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/weighted_centroid_cluster_tracker_core.sv]
// ----------------------------------------------------------------------------
// weighted_centroid_cluster_tracker_core
// Single-object tracker: seeds on the first point, gates later points by
// radius around the weighted centroid, and keeps a majority class vote.
// ----------------------------------------------------------------------------
// One point is handled at a time; req_chan.ready is high only while the
// sequencer is idle. A rejected point skips the sum update and the divider.
// For a seed or an accepted point both centroid coordinates are recomputed
// by one shared restoring divider that retires two quotient bits per cycle
// over the 48-bit weighted sum. A single shared multiplier forms the squared
// distances, the squared radius and the weighted positions. The result sits
// in an output register, so the next point can be taken while it waits for
// rsp_chan.ready. The user must write the radius register through
// csr_wr_en/csr_wr_data only while idle; the block does not enforce it.
`default_nettype none

module weighted_centroid_cluster_tracker_core #(
   parameter int COORD_BITS = wcct_pkg::COORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   wcct_req_if.sink                           req_chan,
   wcct_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [wcct_pkg::RADIUS_W-1:0] csr_wr_data
);
   import wcct_pkg::*;

   localparam int CB        = COORD_BITS;
   localparam int MA_W      = (CB + 1 > RADIUS_W + 1) ? CB + 1 : RADIUS_W + 1;
   localparam int MB_W      = WEIGHT_W + 1;
   localparam int PW        = MA_W + MB_W;
   localparam int SA_W      = ((PW > SUM_W) ? PW : SUM_W) + 1;
   localparam int SQ_W      = 2 * RADIUS_W;
   localparam int DIV_STEPS = SUM_W / 2;
   localparam int DCNT_W    = $clog2(DIV_STEPS);

   localparam logic signed [SA_W-1:0] SA_MAX = SA_W'(SUM_MAX);
   localparam logic signed [SA_W-1:0] SA_MIN = SA_W'(SUM_MIN);
   localparam logic [SUM_W-1:0] Q_POS_MAX = (SUM_W'(1) << (CB - 1)) - SUM_W'(1);
   localparam logic [SUM_W-1:0] Q_NEG_MAX = SUM_W'(1) << (CB - 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DIST = 4'd1;
   localparam logic [3:0] S_SQX  = 4'd2;
   localparam logic [3:0] S_SQY  = 4'd3;
   localparam logic [3:0] S_SQR  = 4'd4;
   localparam logic [3:0] S_CMP  = 4'd5;
   localparam logic [3:0] S_MX   = 4'd6;
   localparam logic [3:0] S_MY   = 4'd7;
   localparam logic [3:0] S_UPD  = 4'd8;
   localparam logic [3:0] S_DLD  = 4'd9;
   localparam logic [3:0] S_DRUN = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a,
      input logic signed [PW-1:0]    b
   );
      logic signed [SA_W-1:0] s;
      s = SA_W'(a) + SA_W'(b);
      if (s > SA_MAX) begin
         return SUM_MAX;
      end else if (s < SA_MIN) begin
         return SUM_MIN;
      end
      return s[SUM_W-1:0];
   endfunction

   logic [3:0]                state_ff, state_in;
   logic [RADIUS_W-1:0]       radius_ff;

   logic signed [CB-1:0]      px_ff, py_ff;
   logic [WEIGHT_W-1:0]       w_ff;
   logic [CLASS_W-1:0]        vote_ff;

   logic                      seeded_ff;
   logic signed [SUM_W-1:0]   sum_x_ff, sum_y_ff;
   logic [TW_W-1:0]           tw_ff;
   logic [CLASS_W-1:0]        class_ff;
   vote_cnt_type              votes_ff;
   logic [CNT_W-1:0]          acc_cnt_ff;
   logic signed [CB-1:0]      cx_ff, cy_ff;

   logic [MA_W-1:0]           dx_ff, dy_ff;
   logic                      far_ff;
   logic [SQ_W:0]             sq_ff;
   logic signed [PW-1:0]      prod_ff;
   logic                      incl_ff;

   logic [TW_W-1:0]           rem_ff;
   logic [SUM_W-1:0]          quo_ff;
   logic                      neg_ff;
   logic [DCNT_W-1:0]         dcnt_ff;
   logic                      dsel_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_incl_ff;
   logic [CLASS_W-1:0]        rsp_class_ff;
   logic signed [CB-1:0]      rsp_cx_ff, rsp_cy_ff;
   logic [CNT_W-1:0]          rsp_cnt_ff;

   logic                      req_xfer;
   logic                      rsp_load;
   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic signed [PW-1:0]      prod_in;
   logic signed [CB:0]        diff_x, diff_y;
   logic [CB:0]               adx, ady;
   logic [TW_W:0]             tw_sum;
   vote_cnt_type              votes_in;
   logic [CLASS_W-1:0]        best;
   logic [TW_W:0]             r1, r2;
   logic [TW_W-1:0]           rem_a, rem_b;
   logic                      qb1, qb2;
   logic [SUM_W-1:0]          quo_in;
   logic signed [SUM_W-1:0]   div_src;
   logic [CB-1:0]             q_sat;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.included     = rsp_incl_ff;
   assign rsp_chan.object_class = rsp_class_ff;
   assign rsp_chan.centroid_x   = rsp_cx_ff;
   assign rsp_chan.centroid_y   = rsp_cy_ff;
   assign rsp_chan.update_count = rsp_cnt_ff;

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQX: begin
            mul_a = MA_W'(dx_ff[RADIUS_W-1:0]);
            mul_b = MB_W'(dx_ff[RADIUS_W-1:0]);
         end
         S_SQY: begin
            mul_a = MA_W'(dy_ff[RADIUS_W-1:0]);
            mul_b = MB_W'(dy_ff[RADIUS_W-1:0]);
         end
         S_SQR: begin
            mul_a = MA_W'(radius_ff);
            mul_b = MB_W'(radius_ff);
         end
         S_MX: begin
            mul_a = MA_W'(px_ff);
            mul_b = MB_W'(w_ff);
         end
         S_MY: begin
            mul_a = MA_W'(py_ff);
            mul_b = MB_W'(w_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PW'(mul_a) * PW'(mul_b);

   assign diff_x = (CB + 1)'(px_ff) - (CB + 1)'(cx_ff);
   assign diff_y = (CB + 1)'(py_ff) - (CB + 1)'(cy_ff);
   assign adx    = diff_x[CB] ? unsigned'(-diff_x) : unsigned'(diff_x);
   assign ady    = diff_y[CB] ? unsigned'(-diff_y) : unsigned'(diff_y);

   assign tw_sum = {1'b0, tw_ff} + (TW_W + 1)'(w_ff);

   always_comb begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
         votes_in[i] = votes_ff[i];
      end
      if (vote_ff != CLASS_NONE && votes_ff[vote_ff - CLASS_1] != CNT_MAX) begin
         votes_in[vote_ff - CLASS_1] = votes_ff[vote_ff - CLASS_1] + CNT_W'(1);
      end
      best = CLASS_1;
      if (votes_in[1] > votes_in[0]) begin
         best = CLASS_2;
      end
      if (votes_in[2] > votes_in[best - CLASS_1]) begin
         best = CLASS_3;
      end
   end

   // divider: two restoring steps per cycle
   always_comb begin
      r1     = {rem_ff, quo_ff[SUM_W-1]};
      qb1    = (r1 >= {1'b0, tw_ff});
      rem_a  = qb1 ? TW_W'(r1 - {1'b0, tw_ff}) : r1[TW_W-1:0];
      r2     = {rem_a, quo_ff[SUM_W-2]};
      qb2    = (r2 >= {1'b0, tw_ff});
      rem_b  = qb2 ? TW_W'(r2 - {1'b0, tw_ff}) : r2[TW_W-1:0];
      quo_in = {quo_ff[SUM_W-3:0], qb1, qb2};
      div_src = dsel_ff ? sum_y_ff : sum_x_ff;
      if (tw_ff == '0) begin
         q_sat = '0;
      end else if (!neg_ff) begin
         q_sat = (quo_in > Q_POS_MAX) ? Q_POS_MAX[CB-1:0] : quo_in[CB-1:0];
      end else begin
         q_sat = (quo_in > Q_NEG_MAX) ? Q_NEG_MAX[CB-1:0] : CB'(-quo_in);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = seeded_ff ? S_DIST : S_MX;
            end
         end
         S_DIST: state_in = S_SQX;
         S_SQX:  state_in = S_SQY;
         S_SQY:  state_in = S_SQR;
         S_SQR:  state_in = S_CMP;
         S_CMP: begin
            if (!far_ff && sq_ff <= (SQ_W + 1)'(prod_ff[SQ_W-1:0])) begin
               state_in = S_MX;
            end else begin
               state_in = S_OUT;
            end
         end
         S_MX:   state_in = S_MY;
         S_MY:   state_in = S_UPD;
         S_UPD:  state_in = S_DLD;
         S_DLD:  state_in = S_DRUN;
         S_DRUN: begin
            if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               state_in = dsel_ff ? S_OUT : S_DLD;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         radius_ff    <= '0;
         seeded_ff    <= 1'b0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         tw_ff        <= '0;
         class_ff     <= CLASS_NONE;
         acc_cnt_ff   <= '0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         dsel_ff      <= 1'b0;
         dcnt_ff      <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            votes_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
         if (state_ff == S_MY) begin
            sum_x_ff <= sat_add(sum_x_ff, prod_ff);
         end
         if (state_ff == S_UPD) begin
            sum_y_ff  <= sat_add(sum_y_ff, prod_ff);
            tw_ff     <= tw_sum[TW_W] ? TW_MAX : tw_sum[TW_W-1:0];
            votes_ff  <= votes_in;
            seeded_ff <= 1'b1;
            dsel_ff   <= 1'b0;
            if (seeded_ff) begin
               class_ff <= best;
               if (acc_cnt_ff != CNT_MAX) begin
                  acc_cnt_ff <= acc_cnt_ff + CNT_W'(1);
               end
            end else begin
               class_ff <= vote_ff;
            end
         end
         if (state_ff == S_DLD) begin
            dcnt_ff <= '0;
         end
         if (state_ff == S_DRUN) begin
            dcnt_ff <= dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               if (dsel_ff) begin
                  cy_ff <= q_sat;
               end else begin
                  cx_ff   <= q_sat;
                  dsel_ff <= 1'b1;
               end
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         px_ff   <= req_chan.pos_x;
         py_ff   <= req_chan.pos_y;
         w_ff    <= req_chan.weight;
         vote_ff <= req_chan.class_vote;
         incl_ff <= 1'b0;
      end
      prod_ff <= prod_in;
      case (state_ff)
         S_DIST: begin
            dx_ff <= MA_W'(adx);
            dy_ff <= MA_W'(ady);
         end
         S_SQX: begin
            far_ff <= (dx_ff > MA_W'(radius_ff)) || (dy_ff > MA_W'(radius_ff));
         end
         S_SQY: begin
            sq_ff <= (SQ_W + 1)'(prod_ff[SQ_W-1:0]);
         end
         S_SQR: begin
            sq_ff <= sq_ff + (SQ_W + 1)'(prod_ff[SQ_W-1:0]);
         end
         S_UPD: begin
            incl_ff <= 1'b1;
         end
         S_DLD: begin
            neg_ff <= div_src[SUM_W-1];
            quo_ff <= div_src[SUM_W-1] ? unsigned'(-div_src) : unsigned'(div_src);
            rem_ff <= '0;
         end
         S_DRUN: begin
            quo_ff <= quo_in;
            rem_ff <= rem_b;
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_incl_ff  <= incl_ff;
         rsp_class_ff <= class_ff;
         rsp_cx_ff    <= cx_ff;
         rsp_cy_ff    <= cy_ff;
         rsp_cnt_ff   <= acc_cnt_ff;
      end
   end

endmodule

`default_nettype wire

[test/weighted_centroid_cluster_tracker_core_checker.sv]
// ----------------------------------------------------------------------------
// weighted_centroid_cluster_tracker_core_checker
// Watches the point, result and radius ports of the tracker and keeps its
// own copy of the object: seed, radius gate, weighted sums, votes and count.
// Each point transfer queues the predicted result. Each result transfer is
// compared field by field with the oldest prediction. Mismatches are counted
// and handed to the test top.
// ----------------------------------------------------------------------------
module weighted_centroid_cluster_tracker_core_checker #(
   parameter int COORD_BITS = wcct_pkg::COORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   wcct_req_if                                req_mon,
   wcct_rsp_if                                rsp_mon,
   input  wire logic                          csr_wr_en,
   input  wire logic [wcct_pkg::RADIUS_W-1:0] csr_wr_data,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 included_seen,
   output int                                 rejected_seen,
   output logic signed [COORD_BITS-1:0]       track_x,
   output logic signed [COORD_BITS-1:0]       track_y
);
   timeunit 1ns;
   timeprecision 1ps;

   import wcct_pkg::*;

   typedef struct packed {
      logic                         included;
      logic [CLASS_W-1:0]           object_class;
      logic signed [COORD_BITS-1:0] centroid_x;
      logic signed [COORD_BITS-1:0] centroid_y;
      logic [CNT_W-1:0]             update_count;
   } track_result_type;

   localparam longint COORD_HI = (longint'(1) << (COORD_BITS - 1)) - 1;
   localparam longint COORD_LO = -COORD_HI - 1;

   track_result_type    expected_track[$];
   logic [RADIUS_W-1:0] radius;
   bit                  seeded;
   longint              wsum_x;
   longint              wsum_y;
   longint              wtotal;
   logic [CLASS_W-1:0]  obj_class;
   int unsigned         votes [NUM_CLASSES];
   int unsigned         accepts;

   function automatic longint clip_sum(longint a, longint b);
      longint r;
      r = a + b;
      if (r > longint'(SUM_MAX)) return longint'(SUM_MAX);
      if (r < longint'(SUM_MIN)) return longint'(SUM_MIN);
      return r;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] centroid_of(longint s);
      longint q;
      if (wtotal == 0) return '0;
      q = s / wtotal;
      if (q > COORD_HI) q = COORD_HI;
      if (q < COORD_LO) q = COORD_LO;
      return q[COORD_BITS-1:0];
   endfunction

   function automatic void fold_point(longint px, longint py, longint w,
                                      logic [CLASS_W-1:0] v);
      wsum_x = clip_sum(wsum_x, px * w);
      wsum_y = clip_sum(wsum_y, py * w);
      wtotal = wtotal + w;
      if (wtotal > longint'(TW_MAX)) wtotal = longint'(TW_MAX);
      if (v != CLASS_NONE && votes[int'(v) - 1] < CNT_MAX) votes[int'(v) - 1]++;
   endfunction

   function automatic track_result_type track_point(longint px, longint py, longint w,
                                                    logic [CLASS_W-1:0] v);
      track_result_type   res;
      longint             dx;
      longint             dy;
      longint             r;
      logic [CLASS_W-1:0] best;
      res.included = 1'b0;
      if (!seeded) begin
         seeded = 1'b1;
         fold_point(px, py, w, v);
         obj_class = v;
         res.included = 1'b1;
      end else begin
         dx = px - longint'(centroid_of(wsum_x));
         dy = py - longint'(centroid_of(wsum_y));
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         r = longint'(radius);
         if (dx <= r && dy <= r && dx * dx + dy * dy <= r * r) begin
            fold_point(px, py, w, v);
            if (accepts < CNT_MAX) accepts++;
            best = CLASS_1;
            if (votes[1] > votes[0]) best = CLASS_2;
            if (votes[2] > votes[int'(best) - 1]) best = CLASS_3;
            obj_class = best;
            res.included = 1'b1;
         end
      end
      res.object_class = obj_class;
      res.centroid_x   = centroid_of(wsum_x);
      res.centroid_y   = centroid_of(wsum_y);
      res.update_count = accepts[CNT_W-1:0];
      return res;
   endfunction

   function automatic void check_field(string field, longint want, longint got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      track_result_type want;
      if (reset) begin
         expected_track.delete();
         radius    = '0;
         seeded    = 1'b0;
         wsum_x    = 0;
         wsum_y    = 0;
         wtotal    = 0;
         obj_class = CLASS_NONE;
         votes     = '{default: 0};
         accepts   = 0;
      end else begin
         if (csr_wr_en) radius = csr_wr_data;
         if (req_mon.valid && req_mon.ready) begin
            want = track_point(longint'(req_mon.pos_x),
                               longint'(req_mon.pos_y),
                               longint'(req_mon.weight),
                               req_mon.class_vote);
            expected_track = {expected_track, want};
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_track.size() == 0) begin
               fail_count++;
               $display("%0t: result with nothing expected: included %0d class %0d",
                        $time, rsp_mon.included, rsp_mon.object_class);
            end else begin
               want = expected_track.pop_front();
               check_field("included", want.included, rsp_mon.included);
               check_field("object_class", want.object_class, rsp_mon.object_class);
               check_field("centroid_x", want.centroid_x, rsp_mon.centroid_x);
               check_field("centroid_y", want.centroid_y, rsp_mon.centroid_y);
               check_field("update_count", want.update_count, rsp_mon.update_count);
               if (want.included) included_seen++;
               else rejected_seen++;
            end
         end
      end
      pending = expected_track.size();
      track_x = centroid_of(wsum_x);
      track_y = centroid_of(wsum_y);
   end

endmodule

[test/weighted_centroid_cluster_tracker_core_test.sv]
// ----------------------------------------------------------------------------
// weighted_centroid_cluster_tracker_core_test
// Drives weighted points into the tracker in random bursts, stalls the result
// side on changing patterns and steps the radius through several settings.
// A directed opening hits the seed, zero weight, vote zero, vote ties and the
// radius edges; random phases then aim points inside, on and just past the
// radius circle around the predicted centroid, mixed with full-range noise.
// ----------------------------------------------------------------------------
module weighted_centroid_cluster_tracker_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import wcct_pkg::*;

   localparam int                  POINTS_PER_PHASE = 150;
   localparam int                  RANDOM_PHASES    = 9;
   localparam int                  DRAIN_WAIT       = 80;
   localparam int                  STALL_LIMIT      = 2000;
   localparam longint              INSIDE_SPAN      = 20000;
   localparam logic [RADIUS_W-1:0] RADIUS_MAX       = {RADIUS_W{1'b1}};
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX       = {WEIGHT_W{1'b1}};

   typedef enum {PT_INSIDE, PT_RIM, PT_OUTSIDE, PT_NOISE} point_kind_type;
   typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_COMB, DRAIN_LONG} drain_mode_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_wr_en;
   logic [RADIUS_W-1:0]              csr_wr_data;
   int                               fail_count;
   int                               pending;
   int                               included_seen;
   int                               rejected_seen;
   logic signed [COORD_BITS_DEF-1:0] track_x;
   logic signed [COORD_BITS_DEF-1:0] track_y;
   logic [RADIUS_W-1:0]              radius_now;
   int                               burst_left;
   int                               points_sent;
   int                               radius_writes;
   int                               idle_cycles = 0;

   wcct_req_if req_chan ();
   wcct_rsp_if rsp_chan ();

   weighted_centroid_cluster_tracker_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   weighted_centroid_cluster_tracker_core_checker track_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .included_seen (included_seen),
      .rejected_seen (rejected_seen),
      .track_x       (track_x),
      .track_y       (track_y)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic logic signed [COORD_BITS_DEF-1:0] clamp_coord(longint v);
      longint hi;
      hi = (longint'(1) << (COORD_BITS_DEF - 1)) - 1;
      if (v > hi) v = hi;
      if (v < -hi - 1) v = -hi - 1;
      return v[COORD_BITS_DEF-1:0];
   endfunction

   // offsets are taken around the predicted centroid when rel is set
   task automatic push_point(bit rel, longint x, longint y, logic [WEIGHT_W-1:0] w,
                             logic [CLASS_W-1:0] v);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid      = 1'b1;
      req_chan.pos_x      = rel ? clamp_coord(longint'(track_x) + x) : clamp_coord(x);
      req_chan.pos_y      = rel ? clamp_coord(longint'(track_y) + y) : clamp_coord(y);
      req_chan.weight     = w;
      req_chan.class_vote = v;
      do @(posedge clock); while (!req_chan.ready);
      points_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic set_radius(logic [RADIUS_W-1:0] r);
      settle();
      csr_wr_en   = 1'b1;
      csr_wr_data = r;
      radius_now  = r;
      radius_writes++;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic random_point();
      point_kind_type      kind;
      int                  pick;
      longint              r;
      longint              span;
      longint              ox;
      longint              oy;
      logic [WEIGHT_W-1:0] w;
      r = longint'(radius_now);
      span = (r > INSIDE_SPAN) ? INSIDE_SPAN : r;
      pick = $urandom_range(0, 99);
      kind = (pick < 60) ? PT_INSIDE : (pick < 75) ? PT_RIM :
             (pick < 85) ? PT_OUTSIDE : PT_NOISE;
      case (kind)
         PT_INSIDE: begin
            ox = longint'($urandom_range(0, 2 * span)) - span;
            oy = longint'($urandom_range(0, 2 * span)) - span;
         end
         PT_RIM: begin
            ox = longint'($urandom_range(0, 2 * r)) - r;
            oy = longint'($floor($sqrt(real'(r * r - ox * ox)))) + $urandom_range(0, 1);
            if ($urandom_range(0, 1)) oy = -oy;
         end
         PT_OUTSIDE: begin
            ox = r + $urandom_range(1, 3);
            oy = longint'($urandom_range(0, 6)) - 3;
            if ($urandom_range(0, 1)) ox = -ox;
            if ($urandom_range(0, 1)) begin
               r = ox;
               ox = oy;
               oy = r;
            end
         end
         default: begin
            ox = longint'($urandom_range(0, 65535)) - 32768;
            oy = longint'($urandom_range(0, 65535)) - 32768;
         end
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0) w = '0;
      else if (pick == 1) w = WEIGHT_MAX;
      else if (pick < 5) w = WEIGHT_W'($urandom_range(1, 512));
      else w = WEIGHT_W'($urandom_range(0, 65535));
      push_point(kind != PT_NOISE, ox, oy, w, CLASS_W'($urandom_range(0, 3)));
   endtask

   initial begin
      drain_mode_type mode;
      int             left;
      int             tick;
      rsp_chan.ready = 1'b0;
      mode = DRAIN_FREE;
      left = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = drain_mode_type'($urandom_range(0, 3));
            left = $urandom_range(50, 400);
         end
         left--;
         tick++;
         case (mode)
            DRAIN_FREE: rsp_chan.ready = 1'b1;
            DRAIN_COIN: rsp_chan.ready = ($urandom_range(0, 3) != 0);
            DRAIN_COMB: rsp_chan.ready = (tick % 9) < 4;
            default:    rsp_chan.ready = (tick % 64) >= 40;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("weighted_centroid_cluster_tracker_core_test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_chan.valid      = 1'b0;
      req_chan.pos_x      = '0;
      req_chan.pos_y      = '0;
      req_chan.weight     = '0;
      req_chan.class_vote = CLASS_NONE;
      radius_now          = '0;
      burst_left          = 0;
      points_sent         = 0;
      radius_writes       = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // radius still at its reset value of zero
      push_point(1'b0, -32768, 32767, '0, CLASS_NONE);
      push_point(1'b1, 0, 0, '0, CLASS_NONE);
      push_point(1'b1, 1, 0, 16'd5, CLASS_2);
      push_point(1'b1, 0, 0, WEIGHT_MAX, CLASS_3);

      set_radius(RADIUS_MAX);
      push_point(1'b0, 32767, 32767, WEIGHT_MAX, CLASS_2);
      push_point(1'b0, -32768, -32768, WEIGHT_MAX, CLASS_1);
      push_point(1'b1, -30000, 0, 16'd256, CLASS_1);

      set_radius(16'd100);
      push_point(1'b1, 101, 0, 16'd256, CLASS_1);
      push_point(1'b1, 0, -101, 16'd256, CLASS_1);
      push_point(1'b1, 71, 71, 16'd256, CLASS_1);
      push_point(1'b1, 60, -80, 16'd256, CLASS_2);
      push_point(1'b1, -100, 0, '0, CLASS_NONE);
      push_point(1'b1, 0, 100, WEIGHT_MAX, CLASS_3);
      push_point(1'b1, -70, -70, 16'd1, CLASS_3);

      set_radius(16'd1);
      push_point(1'b1, 1, 1, 16'd100, CLASS_1);
      push_point(1'b1, 1, 0, 16'd100, CLASS_1);
      push_point(1'b1, 0, -1, WEIGHT_MAX, CLASS_2);

      set_radius('0);
      push_point(1'b1, 0, 0, WEIGHT_MAX, CLASS_NONE);
      push_point(1'b1, 0, 1, 16'd7, CLASS_1);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 6)
            0:       set_radius(RADIUS_MAX);
            1:       set_radius('0);
            2:       set_radius(RADIUS_W'($urandom_range(1, 8)));
            3:       set_radius(RADIUS_W'($urandom_range(9, 300)));
            4:       set_radius(RADIUS_W'($urandom_range(301, 8000)));
            default: set_radius(RADIUS_W'($urandom_range(0, 65535)));
         endcase
         repeat (POINTS_PER_PHASE) random_point();
      end

      settle();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d points sent under %0d radius settings", points_sent, radius_writes);
      $display("%0d results included the point, %0d rejected it",
               included_seen, rejected_seen);
      if (fail_count == 0) begin
         $display("weighted_centroid_cluster_tracker_core_test passed");
      end else begin
         $display("weighted_centroid_cluster_tracker_core_test failed");
      end
      $finish;
   end

endmodule
